/* design/ppmu_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and a helper function for the packed pixel mask unpacker.
// No dependencies; every other design file uses this package.
package ppmu_pkg;

  localparam int MaxBytesPerPixel = 4;
  localparam int MaskW            = 32;
  localparam int ChanW            = 8;
  localparam int NumChan          = 4;
  localparam int BppW             = 6;
  localparam int TotalW           = 25;
  localparam int CountW           = 24;
  localparam int ByteCntW         = 3;
  localparam int CfgIdxW          = 3;
  localparam int QueueDepth       = 2;
  localparam int ShiftW           = 5;
  localparam int LeftW            = 4;

  localparam logic [TotalW-1:0] PixelsCap = TotalW'(1 << CountW);

  typedef enum logic [CfgIdxW-1:0] {
    CfgRedMask       = 3'd0,
    CfgGreenMask     = 3'd1,
    CfgBlueMask      = 3'd2,
    CfgAlphaMask     = 3'd3,
    CfgBitsPerPixel  = 3'd4,
    CfgAlphaEnable   = 3'd5,
    CfgPixelsInImage = 3'd6
  } cfg_idx_e;

  typedef enum int {
    ChRed   = 0,
    ChGreen = 1,
    ChBlue  = 2,
    ChAlpha = 3
  } chan_sel_e;

  // per-channel shift setup, derived from the mask when it is written
  typedef struct packed {
    logic              nz;
    logic [ShiftW-1:0] rsh;
    logic [LeftW-1:0]  lsh;
  } chan_t;

  localparam chan_t ChanReset = '{nz: 1'b0, rsh: '0, lsh: LeftW'(ChanW)};

  typedef struct packed {
    logic [ByteCntW-1:0] bytes;
    logic [CountW-1:0]   total_m1;
  } front_cfg_t;

  typedef struct packed {
    logic [NumChan-1:0][MaskW-1:0] mask;
    chan_t [NumChan-1:0]           chan;
    logic                          alpha_en;
  } back_cfg_t;

  function automatic chan_t chan_derive(input logic [MaskW-1:0] mask);
    chan_t             c;
    logic [MaskW-1:0]  rest;
    logic              run_on;
    logic [LeftW-1:0]  run;
    c.nz  = |mask;
    c.rsh = '0;
    for (int i = MaskW - 1; i >= 0; i--) begin
      if (mask[i]) begin
        c.rsh = ShiftW'(i);
      end
    end
    rest   = mask >> c.rsh;
    run    = '0;
    run_on = 1'b1;
    for (int i = 0; i < ChanW; i++) begin
      if (run_on && rest[i]) begin
        run = run + LeftW'(1);
      end else begin
        run_on = 1'b0;
      end
    end
    c.lsh = LeftW'(ChanW) - run;
    return c;
  endfunction

endpackage

/* design/ppmu_cfg.sv */
`timescale 1ns / 1ps
// Configuration register file; stores masks and precomputed shift setup.
// Depends on ppmu_pkg.
module ppmu_cfg #(
  parameter int MaxBytesPerPixel = ppmu_pkg::MaxBytesPerPixel
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ppmu_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ppmu_pkg::MaskW-1:0]    cfg_data_i,
  output ppmu_pkg::front_cfg_t          front_cfg_o,
  output ppmu_pkg::back_cfg_t           back_cfg_o
);

  localparam int SumW = ppmu_pkg::BppW + 1;

  ppmu_pkg::front_cfg_t front_q;
  ppmu_pkg::back_cfg_t  back_q;
  logic                 wr;
  logic [SumW-1:0]      bpp_sum;
  logic [3:0]           bytes_raw;
  logic [ppmu_pkg::ByteCntW-1:0] bytes_d;
  logic [ppmu_pkg::TotalW-1:0]   total_raw;
  logic [ppmu_pkg::CountW-1:0]   total_m1_d;
  ppmu_pkg::chan_t               chan_d;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i & cfg_ready_o;

  always_comb begin
    bpp_sum   = SumW'(cfg_data_i[ppmu_pkg::BppW-1:0]) + SumW'(7);
    bytes_raw = 4'(bpp_sum >> 3);
    if (bytes_raw == 4'd0) begin
      bytes_d = ppmu_pkg::ByteCntW'(1);
    end else if (bytes_raw > 4'(MaxBytesPerPixel)) begin
      bytes_d = ppmu_pkg::ByteCntW'(MaxBytesPerPixel);
    end else begin
      bytes_d = ppmu_pkg::ByteCntW'(bytes_raw);
    end
    total_raw = cfg_data_i[ppmu_pkg::TotalW-1:0];
    if (total_raw == '0) begin
      total_m1_d = '0;
    end else if (total_raw > ppmu_pkg::PixelsCap) begin
      total_m1_d = '1;
    end else begin
      total_m1_d = ppmu_pkg::CountW'(total_raw - ppmu_pkg::TotalW'(1));
    end
    chan_d = ppmu_pkg::chan_derive(cfg_data_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q.bytes    <= ppmu_pkg::ByteCntW'(MaxBytesPerPixel);
      front_q.total_m1 <= '0;
      back_q.mask      <= '0;
      back_q.chan      <= {ppmu_pkg::NumChan{ppmu_pkg::ChanReset}};
      back_q.alpha_en  <= 1'b0;
    end else if (wr) begin
      unique case (ppmu_pkg::cfg_idx_e'(cfg_index_i))
        ppmu_pkg::CfgRedMask: begin
          back_q.mask[ppmu_pkg::ChRed] <= cfg_data_i;
          back_q.chan[ppmu_pkg::ChRed] <= chan_d;
        end
        ppmu_pkg::CfgGreenMask: begin
          back_q.mask[ppmu_pkg::ChGreen] <= cfg_data_i;
          back_q.chan[ppmu_pkg::ChGreen] <= chan_d;
        end
        ppmu_pkg::CfgBlueMask: begin
          back_q.mask[ppmu_pkg::ChBlue] <= cfg_data_i;
          back_q.chan[ppmu_pkg::ChBlue] <= chan_d;
        end
        ppmu_pkg::CfgAlphaMask: begin
          back_q.mask[ppmu_pkg::ChAlpha] <= cfg_data_i;
          back_q.chan[ppmu_pkg::ChAlpha] <= chan_d;
        end
        ppmu_pkg::CfgBitsPerPixel:  front_q.bytes    <= bytes_d;
        ppmu_pkg::CfgAlphaEnable:   back_q.alpha_en  <= cfg_data_i[0];
        ppmu_pkg::CfgPixelsInImage: front_q.total_m1 <= total_m1_d;
        default: ;
      endcase
    end
  end

  assign front_cfg_o = front_q;
  assign back_cfg_o  = back_q;

endmodule

/* design/ppmu_front.sv */
`timescale 1ns / 1ps
// Front end: accepts bytes, gathers them into pixel words, tags the last pixel.
// Depends on ppmu_pkg.
module ppmu_front #(
  parameter int MaxBytesPerPixel = ppmu_pkg::MaxBytesPerPixel,
  localparam int PixW = 8 * MaxBytesPerPixel
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ppmu_pkg::front_cfg_t cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output logic [PixW-1:0]      pixel_o,
  output logic                 last_o
);

  localparam int PosW = (MaxBytesPerPixel > 1) ? $clog2(MaxBytesPerPixel) : 1;

  logic [PosW-1:0]             pos_q, pos_d;
  logic [PixW-1:0]             gather_q, gather_d;
  logic [ppmu_pkg::CountW-1:0] cnt_q, cnt_d;
  logic                        accept;
  logic                        complete;
  logic                        last;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    if (pos_q == '0) begin
      gather_d = PixW'(data_byte_i);
    end else begin
      gather_d = gather_q | (PixW'(data_byte_i) << {pos_q, 3'b000});
    end
    complete = (ppmu_pkg::ByteCntW'(pos_q) + ppmu_pkg::ByteCntW'(1)) >= cfg_i.bytes;
    last     = cnt_q >= cfg_i.total_m1;
    pos_d    = complete ? '0 : pos_q + PosW'(1);
    cnt_d    = last ? '0 : cnt_q + ppmu_pkg::CountW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      gather_q <= '0;
      cnt_q    <= '0;
    end else if (accept) begin
      pos_q    <= pos_d;
      gather_q <= gather_d;
      if (complete) begin
        cnt_q <= cnt_d;
      end
    end
  end

  assign push_o  = accept & complete;
  assign pixel_o = gather_d;
  assign last_o  = last;

endmodule

/* design/ppmu_fifo.sv */
`timescale 1ns / 1ps
// Short queue of completed pixel words between front and back end.
// Depends on ppmu_pkg.
module ppmu_fifo #(
  parameter int Width = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  localparam int Depth = ppmu_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

/* design/ppmu_back.sv */
`timescale 1ns / 1ps
// Back end: masks and shifts each channel out of a pixel word into the output register.
// Depends on ppmu_pkg.
module ppmu_back #(
  parameter int MaxBytesPerPixel = ppmu_pkg::MaxBytesPerPixel,
  localparam int PixW = 8 * MaxBytesPerPixel
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ppmu_pkg::back_cfg_t        cfg_i,
  input  logic                       q_empty_i,
  input  logic [PixW-1:0]            q_pixel_i,
  input  logic                       q_last_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ppmu_pkg::ChanW-1:0] red_o,
  output logic [ppmu_pkg::ChanW-1:0] green_o,
  output logic [ppmu_pkg::ChanW-1:0] blue_o,
  output logic [ppmu_pkg::ChanW-1:0] alpha_o,
  output logic                       end_of_image_o
);

  localparam int WideW = 2 * ppmu_pkg::ChanW;

  logic [ppmu_pkg::MaskW-1:0]                      pix32;
  logic [ppmu_pkg::NumChan-1:0][ppmu_pkg::ChanW-1:0] chan_d, chan_q;
  logic [ppmu_pkg::MaskW-1:0]                      field;
  logic [WideW-1:0]                                wide;
  logic                                            en;
  logic                                            valid_q;
  logic                                            last_q;

  assign pix32 = ppmu_pkg::MaskW'(q_pixel_i);
  assign pop_o = ~q_empty_i & (~valid_q | ~out_stall_i);

  always_comb begin
    field  = '0;
    wide   = '0;
    en     = 1'b0;
    chan_d = '0;
    for (int c = 0; c < ppmu_pkg::NumChan; c++) begin
      field = (pix32 & cfg_i.mask[c]) >> cfg_i.chan[c].rsh;
      wide  = WideW'(field[ppmu_pkg::ChanW-1:0]) << cfg_i.chan[c].lsh;
      en    = cfg_i.chan[c].nz & ((c != ppmu_pkg::ChAlpha) | cfg_i.alpha_en);
      chan_d[c] = en ? wide[ppmu_pkg::ChanW-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      chan_q <= chan_d;
      last_q <= q_last_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign red_o          = chan_q[ppmu_pkg::ChRed];
  assign green_o        = chan_q[ppmu_pkg::ChGreen];
  assign blue_o         = chan_q[ppmu_pkg::ChBlue];
  assign alpha_o        = chan_q[ppmu_pkg::ChAlpha];
  assign end_of_image_o = last_q;

endmodule

/* design/packed_pixel_mask_unpacker.sv */
`timescale 1ns / 1ps
// Top level of the packed pixel mask unpacker.
// Depends on ppmu_pkg, ppmu_cfg, ppmu_front, ppmu_fifo and ppmu_back.
// Usage:
//   Input channel (in_valid_i / in_stall_o / data_byte_i) carries one raw image
//   byte per beat, least significant byte of each pixel first.
//   Output channel (out_valid_o / out_stall_i) carries one beat per completed
//   pixel: red, green, blue, alpha (0 unless enabled) and end_of_image on the
//   last pixel of each image.
//   Config channel (cfg_valid_i / cfg_ready_o) writes register cfg_index_i with
//   cfg_data_i; ready is always high. Write only while no pixel is in flight.
// Timing:
//   One byte per cycle while in_stall_o is low. The byte gatherer pushes each
//   pixel to a two-entry queue as its last byte is taken; the channel extractor
//   drains it into the output register, one pixel per cycle while not stalled.
// Reset:
//   Masks clear, bits per pixel is 32, pixel count is 1, the gather and pixel
//   counter restart at the first byte of a new image.
// Stall:
//   A stalled output beat holds; the queue absorbs up to two more pixels,
//   after which in_stall_o rises until the output drains.
module packed_pixel_mask_unpacker #(
  parameter int MaxBytesPerPixel = ppmu_pkg::MaxBytesPerPixel
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   data_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ppmu_pkg::ChanW-1:0]   red_o,
  output logic [ppmu_pkg::ChanW-1:0]   green_o,
  output logic [ppmu_pkg::ChanW-1:0]   blue_o,
  output logic [ppmu_pkg::ChanW-1:0]   alpha_o,
  output logic                         end_of_image_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ppmu_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ppmu_pkg::MaskW-1:0]   cfg_data_i
);

  localparam int PixW = 8 * MaxBytesPerPixel;

  ppmu_pkg::front_cfg_t front_cfg;
  ppmu_pkg::back_cfg_t  back_cfg;
  logic                 q_full, q_empty, q_push, q_pop;
  logic [PixW-1:0]      push_pixel, pop_pixel;
  logic                 push_last, pop_last;

  ppmu_cfg #(
    .MaxBytesPerPixel(MaxBytesPerPixel)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .front_cfg_o (front_cfg),
    .back_cfg_o  (back_cfg)
  );

  ppmu_front #(
    .MaxBytesPerPixel(MaxBytesPerPixel)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (front_cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .pixel_o     (push_pixel),
    .last_o      (push_last)
  );

  ppmu_fifo #(
    .Width(PixW + 1)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({push_last, push_pixel}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  ({pop_last, pop_pixel})
  );

  ppmu_back #(
    .MaxBytesPerPixel(MaxBytesPerPixel)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (back_cfg),
    .q_empty_i      (q_empty),
    .q_pixel_i      (pop_pixel),
    .q_last_i       (pop_last),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .alpha_o        (alpha_o),
    .end_of_image_o (end_of_image_o)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push) else $error("push into full pixel queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("pop from empty pixel queue");

  a_single_byte_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && front_cfg.bytes == ppmu_pkg::ByteCntW'(1)) |-> q_push)
    else $error("single-byte pixel not pushed");

  a_pop_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> out_valid_o) else $error("popped pixel did not reach output");
`endif

endmodule

/* bench/ppmu_pixel_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the packed pixel mask unpacker: mirrors the register file,
// gathers input bytes into pixel words and checks every output beat.
// Depends on ppmu_pkg for widths and register indexes.
module ppmu_pixel_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [ppmu_pkg::ChanW-1:0]   red_i,
  input  logic [ppmu_pkg::ChanW-1:0]   green_i,
  input  logic [ppmu_pkg::ChanW-1:0]   blue_i,
  input  logic [ppmu_pkg::ChanW-1:0]   alpha_i,
  input  logic                         end_of_image_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [ppmu_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ppmu_pkg::MaskW-1:0]   cfg_data_i,
  output int                           pending_o,
  output int                           fail_count_o
);
  import ppmu_pkg::*;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
    logic             eoi;
  } pixel_beat_t;

  logic [MaskW-1:0]  chan_mask [NumChan];
  logic [BppW-1:0]   pix_bits;
  logic              alpha_on;
  logic [TotalW-1:0] image_pixels;
  logic [MaskW-1:0]  gather;
  logic [1:0]        gather_pos;
  logic [CountW-1:0] pixels_done;
  pixel_beat_t       expected_beats [$];
  int                mismatches = 0;

  function automatic logic [ChanW-1:0] channel_of(input logic [MaskW-1:0] pixel,
                                                  input logic [MaskW-1:0] mask);
    int               rsh;
    int               run;
    logic [MaskW-1:0] rest;
    logic [MaskW-1:0] v;
    if (mask == '0) return '0;
    rsh = 0;
    while (rsh < 31 && !mask[rsh]) rsh++;
    rest = mask >> rsh;
    run  = 0;
    while (run < 8 && rest[run] && run + rsh < 32) run++;
    v = (pixel & mask) >> rsh;
    v = v << (8 - run);
    return v[ChanW-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] pixel beat mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %02h want %02h", name, got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : model
    pixel_beat_t beat;
    int          bytes;
    int          total;
    if (!rst_ni) begin
      for (int c = 0; c < NumChan; c++) chan_mask[c] = '0;
      pix_bits     = BppW'(32);
      alpha_on     = 1'b0;
      image_pixels = TotalW'(1);
      gather       = '0;
      gather_pos   = '0;
      pixels_done  = '0;
      expected_beats.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("beat arrived with none expected");
        end else begin
          beat = expected_beats.pop_front();
          check_field("red", red_i, beat.red);
          check_field("green", green_i, beat.green);
          check_field("blue", blue_i, beat.blue);
          check_field("alpha", alpha_i, beat.alpha);
          check_field("end_of_image", {7'b0, end_of_image_i}, {7'b0, beat.eoi});
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgRedMask:       chan_mask[ChRed]   = cfg_data_i;
          CfgGreenMask:     chan_mask[ChGreen] = cfg_data_i;
          CfgBlueMask:      chan_mask[ChBlue]  = cfg_data_i;
          CfgAlphaMask:     chan_mask[ChAlpha] = cfg_data_i;
          CfgBitsPerPixel:  pix_bits     = cfg_data_i[BppW-1:0];
          CfgAlphaEnable:   alpha_on     = cfg_data_i[0];
          CfgPixelsInImage: image_pixels = cfg_data_i[TotalW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        bytes = (int'(pix_bits) + 7) >> 3;
        if (bytes < 1) bytes = 1;
        if (bytes > MaxBytesPerPixel) bytes = MaxBytesPerPixel;
        total = int'(image_pixels);
        if (total < 1) total = 1;
        if (total > int'(PixelsCap)) total = int'(PixelsCap);
        if (gather_pos == 2'd0) begin
          gather = MaskW'(data_byte_i);
        end else begin
          gather = gather | (MaskW'(data_byte_i) << (8 * gather_pos));
        end
        if (int'(gather_pos) + 1 < bytes) begin
          gather_pos = gather_pos + 2'd1;
        end else begin
          gather_pos  = '0;
          beat.eoi    = (int'(pixels_done) >= total - 1);
          pixels_done = beat.eoi ? '0 : pixels_done + 1'b1;
          beat.red    = channel_of(gather, chan_mask[ChRed]);
          beat.green  = channel_of(gather, chan_mask[ChGreen]);
          beat.blue   = channel_of(gather, chan_mask[ChBlue]);
          beat.alpha  = alpha_on ? channel_of(gather, chan_mask[ChAlpha]) : '0;
          expected_beats.push_back(beat);
        end
      end
    end
    pending_o    <= expected_beats.size();
    fail_count_o <= mismatches;
  end

endmodule

/* bench/packed_pixel_mask_unpacker_tb.sv */
`timescale 1ns / 1ps
// Testbench top for packed_pixel_mask_unpacker: drives byte, config and
// output channels with random gaps and stalls; ppmu_pixel_checker scores beats.
// Depends on ppmu_pkg, the design files and ppmu_pixel_checker.
module packed_pixel_mask_unpacker_tb;
  import ppmu_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         data_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [ChanW-1:0]   red_o;
  logic [ChanW-1:0]   green_o;
  logic [ChanW-1:0]   blue_o;
  logic [ChanW-1:0]   alpha_o;
  logic               end_of_image_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [MaskW-1:0]   cfg_data_i;

  int fails;
  int pending;
  bit send_quiet;
  bit recv_quiet;

  packed_pixel_mask_unpacker u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .alpha_o        (alpha_o),
    .end_of_image_o (end_of_image_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  ppmu_pixel_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_i          (red_o),
    .green_i        (green_o),
    .blue_i         (blue_o),
    .alpha_i        (alpha_o),
    .end_of_image_i (end_of_image_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pending_o      (pending),
    .fail_count_o   (fails)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // output side: random stall before each beat
  initial begin
    int w;
    out_stall_i = 1'b0;
    @(posedge clk_i);
    forever begin
      w = recv_quiet ? 0 : $urandom_range(0, 19);
      if (w > 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // leaves valid high so back-to-back writes need no re-raise
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [MaskW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_format(input logic [MaskW-1:0] rm, input logic [MaskW-1:0] gm,
                            input logic [MaskW-1:0] bm, input logic [MaskW-1:0] am,
                            input int bpp, input int aen, input int pix);
    cfg_write(CfgRedMask, rm);
    cfg_write(CfgGreenMask, gm);
    cfg_write(CfgBlueMask, bm);
    cfg_write(CfgAlphaMask, am);
    cfg_write(CfgBitsPerPixel, MaskW'(bpp));
    cfg_write(CfgAlphaEnable, MaskW'(aen));
    cfg_write(CfgPixelsInImage, MaskW'(pix));
    cfg_valid_i <= 1'b0;
  endtask

  // drop valid, wait for all beats, then let the pipeline go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [MaskW-1:0] rand_mask();
    logic [63:0] field;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom();
      3: return MaskW'(1) << $urandom_range(0, 31);
      default: begin
        field = ((64'd1 << $urandom_range(1, 12)) - 64'd1) << $urandom_range(0, 31);
        return field[MaskW-1:0];
      end
    endcase
  endfunction

  initial begin
    int random_bytes;
    int bpp;
    int bpix;
    int pix;
    int nbytes;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    send_quiet  = 1'b0;
    recv_quiet  = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset format: zero masks, 32-bit pixels, one-pixel image
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte(8'h5A);
    settle();

    set_format(32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000, 32'hFF00_0000, 32, 1, 2);
    repeat (4) send_byte(8'hFF);
    repeat (4) send_byte(8'h00);
    settle();

    // full, top-bit, bottom-bit and split masks; zero pixel count
    set_format(32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_F81F, 24, 1, 0);
    send_byte(8'h3C);
    send_byte(8'hC3);
    send_byte(8'h81);
    send_byte(8'h7E);
    send_byte(8'hFF);
    send_byte(8'h00);
    settle();

    // zero pixel size, alpha off, pixel count beyond cap
    set_format(32'h0000_00F0, 32'h0000_000E, 32'h0000_0001, 32'hFFFF_FFFF, 0, 0,
               32'h01FF_FFFF);
    send_byte(8'hFF);
    send_byte(8'h96);
    send_byte(8'h01);
    settle();

    // out-of-range index, oversize pixel
    cfg_write(CfgIdxUnused, 32'hFFFF_FFFF);
    set_format(32'h0000_3FFF, 32'hFFFF_0000, 32'h7FFF_FFFE, 32'h8000_0000, 63, 1, 3);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h56);
    send_byte(8'h78);
    settle();

    // pixel size change with a partial gather held
    cfg_write(CfgBitsPerPixel, 32);
    cfg_valid_i <= 1'b0;
    send_byte(8'hA1);
    send_byte(8'hB2);
    settle();
    cfg_write(CfgBitsPerPixel, 9);
    cfg_valid_i <= 1'b0;
    send_byte(8'hC3);
    settle();

    random_bytes = 0;
    while (random_bytes < 1300) begin
      case ($urandom_range(0, 9))
        0:       bpp = 0;
        1:       bpp = $urandom_range(33, 63);
        default: bpp = $urandom_range(1, 32);
      endcase
      case ($urandom_range(0, 9))
        0:       pix = 0;
        1:       pix = $urandom_range(PixelsCap, 32'h01FF_FFFF);
        2:       pix = $urandom_range(1, 32'h01FF_FFFF);
        default: pix = $urandom_range(1, 6);
      endcase
      if ($urandom_range(0, 5) == 0) cfg_write(CfgIdxUnused, $urandom());
      set_format(rand_mask(), rand_mask(), rand_mask(), rand_mask(), bpp,
                 $urandom_range(0, 1), pix);
      bpix = (bpp + 7) / 8;
      if (bpix < 1) bpix = 1;
      if (bpix > MaxBytesPerPixel) bpix = MaxBytesPerPixel;
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);
      nbytes = $urandom_range(2, 16) * bpix;
      // now and then leave a partial pixel behind
      if ($urandom_range(0, 4) == 0) nbytes += $urandom_range(1, 3);
      for (int i = 0; i < nbytes; i++) begin
        case ($urandom_range(0, 7))
          0:       send_byte(8'h00);
          1:       send_byte(8'hFF);
          default: send_byte(8'($urandom_range(0, 255)));
        endcase
      end
      random_bytes += nbytes;
      settle();
    end

    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
